### design/toroidal_life_grid_engine_defines.svh
// Assertion macros for the toroidal life grid engine.
`ifndef TOROIDAL_LIFE_GRID_ENGINE_DEFINES_SVH
`define TOROIDAL_LIFE_GRID_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define TLG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tlg assertion failed");
`define TLG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tlg assertion failed");
`else
`define TLG_ASSERT_NOW(lbl, ante, cons)
`define TLG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### design/tlg_pkg.sv
// Shared constants, types and coordinate wrap tables for the life grid engine.
package tlg_pkg;

  localparam int unsigned GRID_COLS = 64;
  localparam int unsigned GRID_ROWS = 64;

  localparam int unsigned CoordW    = 6;
  localparam int unsigned CoordSpan = 2 ** CoordW;
  localparam int unsigned ColW      = $clog2(GRID_COLS);
  localparam int unsigned RowW      = $clog2(GRID_ROWS);
  localparam int unsigned CntW      = $clog2(GRID_ROWS + 3);
  localparam int unsigned NbrW      = 4;

  localparam int unsigned BirthCount   = 3;
  localparam int unsigned SurviveCount = 2;

  typedef logic [GRID_COLS-1:0] row_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_e;

  typedef logic [ColW-1:0] col_tab_t [CoordSpan];
  typedef logic [RowW-1:0] row_tab_t [CoordSpan];

  function automatic col_tab_t make_col_tab();
    col_tab_t t;
    for (int i = 0; i < CoordSpan; i++) begin
      t[i] = ColW'(i % GRID_COLS);
    end
    return t;
  endfunction

  function automatic row_tab_t make_row_tab();
    row_tab_t t;
    for (int i = 0; i < CoordSpan; i++) begin
      t[i] = RowW'(i % GRID_ROWS);
    end
    return t;
  endfunction

  localparam col_tab_t ColWrap = make_col_tab();
  localparam row_tab_t RowWrap = make_row_tab();

endpackage

### design/tlg_next_row.sv
// B3/S23 next-generation logic for one grid row from its wrapped neighbor rows.
module tlg_next_row import tlg_pkg::*; (
  input  row_t top_i,
  input  row_t mid_i,
  input  row_t bot_i,
  output row_t next_o
);

  always_comb begin
    int unsigned cl;
    int unsigned cr;
    logic [NbrW-1:0] n;
    next_o = '0;
    for (int unsigned c = 0; c < GRID_COLS; c++) begin
      cl = (c == 0) ? GRID_COLS - 1 : c - 1;
      cr = (c == GRID_COLS - 1) ? 0 : c + 1;
      n  = NbrW'(top_i[cl]) + NbrW'(top_i[c]) + NbrW'(top_i[cr]) +
           NbrW'(mid_i[cl]) + NbrW'(mid_i[cr]) +
           NbrW'(bot_i[cl]) + NbrW'(bot_i[c]) + NbrW'(bot_i[cr]);
      next_o[c] = (n == NbrW'(BirthCount)) || (mid_i[c] && (n == NbrW'(SurviveCount)));
    end
  end

endmodule

### design/toroidal_life_grid_engine.sv
// Top level of the toroidal life grid engine: banks, sequencer and result register.
//
// Items enter on in_valid_i/in_ready_o with op_i, col_i, row_i, set_alive_i and each
// yields exactly one result on out_valid_o/out_ready_i (alive_o, changed_o,
// advanced_o). run_enable_i is written on cfg_valid_i/cfg_ready_o; cfg_ready_o is
// always high.
// Each bank holds one grid row per memory word, GRID_ROWS words of GRID_COLS bits.
// Read and write items take one read of both banks; a write item then writes the
// updated row back to both banks. A running step reads the current bank one row a
// cycle through a three-row window and writes the new row into the other bank, then
// swaps the banks. A paused step or an unused op reads no bank and goes straight to
// loading its result.
// Items are taken one at a time; a new item is accepted while a result still waits,
// and its result is held back until the output register is free.
// After reset both banks are zeroed by a clearing pass over all GRID_ROWS rows (64),
// one row per cycle, during which in_ready_o is low. run_enable resets to 1.
`include "toroidal_life_grid_engine_defines.svh"

module toroidal_life_grid_engine import tlg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      op_i,
  input  logic [5:0]      col_i,
  input  logic [5:0]      row_i,
  input  logic            set_alive_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            alive_o,
  output logic            changed_o,
  output logic            advanced_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            run_enable_i
);

  localparam int unsigned WinRows = 3;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_ACC   = 5'b00100,
    S_STEP  = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic            cur_q, cur_d;
  logic            run_q;
  op_e             op_q, op_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            val_q, val_d;
  logic [CntW-1:0] dcnt_q, dcnt_d;
  logic            rvalid_q, rvalid_d;
  logic            res_alive_q, res_alive_d;
  logic            res_changed_q, res_changed_d;
  logic            res_adv_q, res_adv_d;
  logic            out_valid_q, out_valid_d;
  logic            alive_q, changed_q, advanced_q;
  logic            out_load;
  logic            shift_en;

  row_t            mem_a [GRID_ROWS];
  row_t            mem_b [GRID_ROWS];
  row_t            rdata_a_q, rdata_b_q;
  row_t            cur_rdata;
  row_t            top_q, mid_q, bot_q;
  row_t            next_row;
  row_t            wd_a, wd_b;
  logic            we_a, we_b, re;
  logic [RowW-1:0] wr_addr, rd_addr;
  logic [ColW-1:0] col_in;
  logic [RowW-1:0] row_in;

  assign col_in      = ColWrap[col_i];
  assign row_in      = RowWrap[row_i];
  assign cur_rdata   = cur_q ? rdata_b_q : rdata_a_q;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign alive_o     = alive_q;
  assign changed_o   = changed_q;
  assign advanced_o  = advanced_q;
  assign shift_en    = (state_q == S_STEP) && rvalid_q;

  tlg_next_row u_next_row (
    .top_i  (top_q),
    .mid_i  (mid_q),
    .bot_i  (bot_q),
    .next_o (next_row)
  );

  always_comb begin
    state_d       = state_q;
    cur_d         = cur_q;
    op_d          = op_q;
    col_d         = col_q;
    row_d         = row_q;
    val_d         = val_q;
    dcnt_d        = dcnt_q;
    rvalid_d      = 1'b0;
    res_alive_d   = res_alive_q;
    res_changed_d = res_changed_q;
    res_adv_d     = res_adv_q;
    out_load      = 1'b0;
    re            = 1'b0;
    rd_addr       = row_in;
    we_a          = 1'b0;
    we_b          = 1'b0;
    wr_addr       = row_q;
    wd_a          = '0;
    wd_b          = '0;

    unique case (state_q)
      S_CLEAR: begin
        we_a    = 1'b1;
        we_b    = 1'b1;
        wr_addr = dcnt_q[RowW-1:0];
        dcnt_d  = CntW'(dcnt_q + 1'b1);
        if (dcnt_q == CntW'(GRID_ROWS - 1)) begin
          dcnt_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d          = op_e'(op_i);
          col_d         = col_in;
          row_d         = row_in;
          val_d         = set_alive_i;
          res_alive_d   = 1'b0;
          res_changed_d = 1'b0;
          res_adv_d     = 1'b0;
          unique case (op_i) inside
            OP_WRITE, OP_READ: begin
              re      = 1'b1;
              state_d = S_ACC;
            end
            OP_STEP: begin
              if (run_q) begin
                re       = 1'b1;
                rd_addr  = RowW'(GRID_ROWS - 1);
                rvalid_d = 1'b1;
                dcnt_d   = '0;
                state_d  = S_STEP;
              end else begin
                state_d = S_FIN;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_ACC: begin
        case (op_q)
          OP_WRITE: begin
            wd_a          = rdata_a_q;
            wd_a[col_q]   = val_q;
            wd_b          = rdata_b_q;
            wd_b[col_q]   = val_q;
            we_a          = 1'b1;
            we_b          = 1'b1;
          end
          OP_READ: begin
            res_alive_d   = cur_rdata[col_q];
            res_changed_d = rdata_a_q[col_q] ^ rdata_b_q[col_q];
          end
          default: ;
        endcase
        state_d = S_FIN;
      end
      S_STEP: begin
        rd_addr  = (dcnt_q == CntW'(GRID_ROWS)) ? '0 : dcnt_q[RowW-1:0];
        re       = rvalid_q && (dcnt_q <= CntW'(GRID_ROWS));
        rvalid_d = re;
        if (rvalid_q) begin
          dcnt_d = CntW'(dcnt_q + 1'b1);
        end
        if (dcnt_q >= CntW'(WinRows)) begin
          // new row goes to the older bank
          wr_addr = dcnt_q[RowW-1:0] - RowW'(WinRows);
          wd_a    = next_row;
          wd_b    = next_row;
          we_a    = cur_q;
          we_b    = !cur_q;
        end
        if (dcnt_q == CntW'(GRID_ROWS + WinRows - 1)) begin
          cur_d     = !cur_q;
          res_adv_d = 1'b1;
          state_d   = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cur_q       <= 1'b0;
      run_q       <= 1'b1;
      dcnt_q      <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      dcnt_q      <= dcnt_d;
      rvalid_q    <= rvalid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        run_q <= run_enable_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    col_q         <= col_d;
    row_q         <= row_d;
    val_q         <= val_d;
    res_alive_q   <= res_alive_d;
    res_changed_q <= res_changed_d;
    res_adv_q     <= res_adv_d;
    if (out_load) begin
      alive_q    <= res_alive_q;
      changed_q  <= res_changed_q;
      advanced_q <= res_adv_q;
    end
    if (shift_en) begin
      top_q <= mid_q;
      mid_q <= bot_q;
      bot_q <= cur_rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wr_addr] <= wd_a;
    end
    if (re) begin
      rdata_a_q <= mem_a[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      mem_b[wr_addr] <= wd_b;
    end
    if (re) begin
      rdata_b_q <= mem_b[rd_addr];
    end
  end

  `TLG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `TLG_ASSERT_NOW(a_step_writes_old_bank, (state_q == S_STEP) && (we_a || we_b), cur_q ? (we_a && !we_b) : (we_b && !we_a))
  `TLG_ASSERT_NOW(a_swap_only_after_step, !$stable(cur_q), $past(state_q == S_STEP))

endmodule
